### rtl/xcfb_pkg.sv
package xcfb_pkg;

    localparam int unsigned MAX_PAYLOAD = 255;
    localparam int unsigned STORE_DEPTH = 256;
    localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
    localparam int unsigned HEADER_LEN  = 6;
    localparam int unsigned POS_W       = 9;
    localparam int unsigned PADDR_W     = 3;

    localparam logic [7:0] START_MARK = 8'h21;
    localparam logic [7:0] END_MARK   = 8'h23;

    localparam logic OP_PAYLOAD = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    localparam logic REG_LOCAL_ADDRESS = 1'b0;

    localparam logic [POS_W-1:0] POS_START   = POS_W'(0);
    localparam logic [POS_W-1:0] POS_LOCAL   = POS_W'(1);
    localparam logic [POS_W-1:0] POS_DEST    = POS_W'(2);
    localparam logic [POS_W-1:0] POS_LENGTH  = POS_W'(3);
    localparam logic [POS_W-1:0] POS_PAY_XOR = POS_W'(4);
    localparam logic [POS_W-1:0] POS_HDR_XOR = POS_W'(5);

    typedef struct packed {
        logic       opcode;
        logic [7:0] payload_byte;
        logic [7:0] destination;
        logic       frame_end;
    } cmd_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       end_marker;
    } result_t;

    typedef struct packed {
        logic [7:0] local_address;
    } cfg_t;

endpackage

### rtl/xcfb_cfg.sv
module xcfb_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [xcfb_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output xcfb_pkg::cfg_t                 cfg
);

    logic [7:0] local_address_reg;
    logic [7:0] local_address_next;
    logic       reg_index;
    logic       wr_en;

    assign reg_index = paddr[2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb
    begin
        local_address_next = local_address_reg;
        if (wr_en && (reg_index == xcfb_pkg::REG_LOCAL_ADDRESS))
        begin
            local_address_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_address_reg <= 8'h00;
        end
        else
        begin
            local_address_reg <= local_address_next;
        end
    end

    always_comb
    begin
        case (reg_index)
            xcfb_pkg::REG_LOCAL_ADDRESS: prdata = {24'h000000, local_address_reg};
            default:                     prdata = 32'h00000000;
        endcase
    end

    assign cfg.local_address = local_address_reg;

endmodule

### rtl/xor_checked_frame_builder.sv
// a payload item gives no result
// a tick item gives its result strobe in the cycle after it is accepted
// throughput: one payload item per cycle while not busy; after a tick item busy
// holds off the next item (busy covers the registered read of the payload store)
// reset: asynchronous active low, clears counters, flags and local_address
// the receiver cannot stall: each result is shown for exactly one cycle
module xor_checked_frame_builder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [xcfb_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    input  xcfb_pkg::cmd_t                cmd,
    output logic                          result_valid,
    output xcfb_pkg::result_t             result
);

    xcfb_pkg::cfg_t cfg;

    xcfb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic [7:0] store_mem [xcfb_pkg::STORE_DEPTH];
    logic [7:0] rd_data_reg;

    logic [7:0]                  count_reg,   count_next;
    logic [7:0]                  xor_reg,     xor_next;
    logic [7:0]                  dest_reg,    dest_next;
    logic                        emitting_reg, emitting_next;
    logic [xcfb_pkg::POS_W-1:0]  pos_reg,     pos_next;
    logic                        pend_reg,    pend_next;
    logic                        sel_mem_reg, sel_mem_next;
    logic [7:0]                  byte_reg,    byte_next;
    logic                        endm_reg,    endm_next;

    logic                        accept;
    logic                        pay_acc;
    logic                        tick_acc;
    logic                        store_wr;
    logic                        rd_en;
    logic [xcfb_pkg::ADDR_W-1:0] rd_addr;
    logic [xcfb_pkg::POS_W-1:0]  pay_end;
    logic [xcfb_pkg::POS_W-1:0]  pay_off;

    assign busy     = pend_reg;
    assign accept   = start && !busy;
    assign pay_acc  = accept && (cmd.opcode == xcfb_pkg::OP_PAYLOAD) && !emitting_reg;
    assign tick_acc = accept && (cmd.opcode == xcfb_pkg::OP_TICK) && emitting_reg;
    assign store_wr = pay_acc && (count_reg < 8'(xcfb_pkg::MAX_PAYLOAD));
    assign pay_end  = xcfb_pkg::POS_W'(xcfb_pkg::HEADER_LEN) + {1'b0, count_reg};
    assign pay_off  = pos_reg - xcfb_pkg::POS_W'(xcfb_pkg::HEADER_LEN);
    assign rd_addr  = pay_off[xcfb_pkg::ADDR_W-1:0];

    always_comb
    begin
        count_next    = count_reg;
        xor_next      = xor_reg;
        dest_next     = dest_reg;
        emitting_next = emitting_reg;
        pos_next      = pos_reg;
        pend_next     = tick_acc;
        sel_mem_next  = 1'b0;
        byte_next     = byte_reg;
        endm_next     = 1'b0;
        rd_en         = 1'b0;

        if (pay_acc)
        begin
            if (store_wr)
            begin
                count_next = count_reg + 8'd1;
                xor_next   = xor_reg ^ cmd.payload_byte;
            end
            if (cmd.frame_end)
            begin
                dest_next     = cmd.destination;
                emitting_next = 1'b1;
                pos_next      = '0;
            end
        end

        if (tick_acc)
        begin
            if (pos_reg == xcfb_pkg::POS_START)
            begin
                byte_next = xcfb_pkg::START_MARK;
            end
            else if (pos_reg == xcfb_pkg::POS_LOCAL)
            begin
                byte_next = cfg.local_address;
            end
            else if (pos_reg == xcfb_pkg::POS_DEST)
            begin
                byte_next = dest_reg;
            end
            else if (pos_reg == xcfb_pkg::POS_LENGTH)
            begin
                byte_next = count_reg;
            end
            else if (pos_reg == xcfb_pkg::POS_PAY_XOR)
            begin
                byte_next = xor_reg;
            end
            else if (pos_reg == xcfb_pkg::POS_HDR_XOR)
            begin
                byte_next = cfg.local_address ^ dest_reg ^ count_reg ^ xor_reg;
            end
            else if (pos_reg < pay_end)
            begin
                sel_mem_next = 1'b1;
                rd_en        = 1'b1;
            end
            else
            begin
                byte_next = xcfb_pkg::END_MARK;
                endm_next = 1'b1;
            end

            if (endm_next)
            begin
                count_next    = 8'd0;
                xor_next      = 8'd0;
                emitting_next = 1'b0;
                pos_next      = '0;
            end
            else
            begin
                pos_next = pos_reg + xcfb_pkg::POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= 8'd0;
            xor_reg      <= 8'd0;
            dest_reg     <= 8'd0;
            emitting_reg <= 1'b0;
            pos_reg      <= '0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            xor_reg      <= xor_next;
            dest_reg     <= dest_next;
            emitting_reg <= emitting_next;
            pos_reg      <= pos_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_mem_reg <= sel_mem_next;
        byte_reg    <= byte_next;
        endm_reg    <= endm_next;
    end

    // payload store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            store_mem[count_reg] <= cmd.payload_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign result_valid      = pend_reg;
    assign result.frame_byte = sel_mem_reg ? rd_data_reg : byte_reg;
    assign result.end_marker = endm_reg;

`ifndef SYNTH
    a_strobe_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(tick_acc))
        else $error("result strobe without a tick item");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.end_marker) |-> (!emitting_reg && count_reg == 8'd0))
        else $error("frame state not cleared after end marker");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 8'(xcfb_pkg::MAX_PAYLOAD))
        else $error("payload count beyond limit");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        emitting_reg |-> (pos_reg <= pay_end))
        else $error("emit position past end of frame");

    a_no_write_emitting: assert property (@(posedge clk) disable iff (!rst_n)
        store_wr |-> !emitting_reg)
        else $error("payload store written during emission");
`endif

endmodule

### bench/xor_checked_frame_builder_tb.sv
`timescale 1ns / 100ps

module xor_checked_frame_builder_tb;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 1650;
    localparam int PHASES       = 5;
    localparam int QUIET_TAIL   = 250;
    localparam logic [xcfb_pkg::PADDR_W-1:0] LOCAL_ADDRESS_OFFSET =
        xcfb_pkg::PADDR_W'(4 * xcfb_pkg::REG_LOCAL_ADDRESS);

    class frame_scoreboard;
        logic [7:0]                 station_addr;
        logic [7:0]                 payload_mem [256];
        logic [7:0]                 byte_count;
        logic [7:0]                 xor_acc;
        logic [7:0]                 dest_hold;
        logic                       sending;
        logic [xcfb_pkg::POS_W-1:0] send_pos;
        xcfb_pkg::result_t          expected_bytes [$];
        int                         errors;

        function new();
            station_addr = 8'h00;
            byte_count   = 8'h00;
            xor_acc      = 8'h00;
            dest_hold    = 8'h00;
            sending      = 1'b0;
            send_pos     = '0;
            errors       = 0;
        endfunction

        task report(input string msg);
            errors++;
            $display("mismatch at %0t: %s", $time, msg);
        endtask

        task note_item(input xcfb_pkg::cmd_t c);
            xcfb_pkg::result_t r;
            int                pos;
            if (c.opcode == xcfb_pkg::OP_PAYLOAD)
            begin
                if (!sending)
                begin
                    if (byte_count < xcfb_pkg::MAX_PAYLOAD)
                    begin
                        payload_mem[byte_count] = c.payload_byte;
                        byte_count = byte_count + 8'd1;
                        xor_acc = xor_acc ^ c.payload_byte;
                    end
                    if (c.frame_end)
                    begin
                        dest_hold = c.destination;
                        sending   = 1'b1;
                        send_pos  = '0;
                    end
                end
            end
            else if (sending)
            begin
                r.end_marker = 1'b0;
                pos = int'(send_pos);
                case (send_pos)
                    xcfb_pkg::POS_START:   r.frame_byte = xcfb_pkg::START_MARK;
                    xcfb_pkg::POS_LOCAL:   r.frame_byte = station_addr;
                    xcfb_pkg::POS_DEST:    r.frame_byte = dest_hold;
                    xcfb_pkg::POS_LENGTH:  r.frame_byte = byte_count;
                    xcfb_pkg::POS_PAY_XOR: r.frame_byte = xor_acc;
                    xcfb_pkg::POS_HDR_XOR:
                        r.frame_byte = station_addr ^ dest_hold ^ byte_count ^ xor_acc;
                    default:
                    begin
                        if (pos < int'(xcfb_pkg::HEADER_LEN) + int'(byte_count))
                            r.frame_byte =
                                payload_mem[8'(pos - int'(xcfb_pkg::HEADER_LEN))];
                        else
                        begin
                            r.frame_byte = xcfb_pkg::END_MARK;
                            r.end_marker = 1'b1;
                        end
                    end
                endcase
                if (r.end_marker)
                begin
                    byte_count = 8'h00;
                    xor_acc    = 8'h00;
                    sending    = 1'b0;
                    send_pos   = '0;
                end
                else
                    send_pos = send_pos + xcfb_pkg::POS_W'(1);
                expected_bytes.push_back(r);
            end
        endtask

        task check_frame_byte(input xcfb_pkg::result_t got);
            xcfb_pkg::result_t want;
            if (expected_bytes.size() == 0)
            begin
                report($sformatf("unexpected frame byte %h end %b",
                                 got.frame_byte, got.end_marker));
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (got.frame_byte !== want.frame_byte)
                    report($sformatf("frame_byte %h, expected %h",
                                     got.frame_byte, want.frame_byte));
                if (got.end_marker !== want.end_marker)
                    report($sformatf("end_marker %b, expected %b",
                                     got.end_marker, want.end_marker));
            end
        endtask
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [xcfb_pkg::PADDR_W-1:0] paddr;
    logic [31:0]                  pwdata;
    logic [31:0]                  prdata;
    logic                         pready;
    logic                         start;
    logic                         busy;
    xcfb_pkg::cmd_t               cmd;
    logic                         result_valid;
    xcfb_pkg::result_t            result;

    frame_scoreboard sb;
    bit              gaps_on;
    int              items_done;

    xor_checked_frame_builder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                sb.check_frame_byte(result);
            if (start && !busy)
                sb.note_item(cmd);
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("xor_checked_frame_builder_tb NOT OK");
        $finish;
    end

    task send_cmd(input xcfb_pkg::cmd_t c);
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy) @(posedge clk);
        items_done++;
    endtask

    task send_payload(input logic [7:0] data, input logic [7:0] dest, input logic last);
        xcfb_pkg::cmd_t c;
        c.opcode       = xcfb_pkg::OP_PAYLOAD;
        c.payload_byte = data;
        c.destination  = dest;
        c.frame_end    = last;
        send_cmd(c);
    endtask

    task send_tick();
        xcfb_pkg::cmd_t c;
        c.opcode       = xcfb_pkg::OP_TICK;
        c.payload_byte = 8'($urandom_range(0, 255));
        c.destination  = 8'($urandom_range(0, 255));
        c.frame_end    = 1'($urandom_range(0, 1));
        send_cmd(c);
    endtask

    // idle ticks and payloads during emission are mixed in as noise
    task send_frame(input int n_bytes);
        int i;
        int n_ticks;
        for (i = 0; i < n_bytes; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_tick();
            send_payload(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         i == n_bytes - 1);
        end
        n_ticks = (n_bytes > int'(xcfb_pkg::MAX_PAYLOAD) ?
                   int'(xcfb_pkg::MAX_PAYLOAD) : n_bytes) +
                  int'(xcfb_pkg::HEADER_LEN) + 1;
        for (i = 0; i < n_ticks; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_payload(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
            send_tick();
        end
        if ($urandom_range(0, 7) == 0)
            send_tick();
    endtask

    task drain();
        int n;
        @(negedge clk);
        start <= 1'b0;
        n = 0;
        while (sb.expected_bytes.size() != 0 && n < 200)
        begin
            @(posedge clk);
            n++;
        end
        if (sb.expected_bytes.size() != 0)
        begin
            sb.report($sformatf("%0d frame bytes never arrived", sb.expected_bytes.size()));
            sb.expected_bytes.delete();
        end
        repeat (4) @(posedge clk);
    endtask

    task write_local_address(input logic [7:0] value);
        logic [31:0] rd;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LOCAL_ADDRESS_OFFSET;
        pwdata  <= {24'($urandom), value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        sb.station_addr = value;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== {24'h0, value})
            sb.report($sformatf("local_address read %h, expected %h", rd, value));
    endtask

    initial
    begin
        int         p;
        int         len;
        logic [7:0] addr;
        sb      = new();
        rst_n   = 1'b0;
        start   = 1'b0;
        cmd     = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        gaps_on = 1'b0;
        items_done = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // tick while idle, then a two-byte frame with extreme values
        send_tick();
        send_payload(8'h00, 8'h00, 1'b0);
        send_payload(8'hFF, 8'hFF, 1'b1);
        send_tick();
        send_tick();
        // payload while emitting is ignored, frame_end included
        send_payload(8'h55, 8'h12, 1'b1);
        repeat (7) send_tick();
        send_tick();
        // single-byte frame
        send_payload(8'h80, 8'h00, 1'b1);
        repeat (8) send_tick();
        drain();

        // overflow, the frame closes on a dropped byte
        write_local_address(8'hA5);
        send_frame(257);
        drain();

        for (p = 0; p < PHASES; p++)
        begin
            drain();
            if (p == 0)
                addr = 8'hFF;
            else if (p == 1)
                addr = 8'h00;
            else
                addr = 8'($urandom_range(0, 255));
            write_local_address(addr);
            while (items_done < (p + 1) * RANDOM_ITEMS / PHASES)
            begin
                gaps_on = (items_done < RANDOM_ITEMS - QUIET_TAIL) &&
                          ($urandom_range(0, 2) != 0);
                if ($urandom_range(0, 15) == 0)
                    len = $urandom_range(240, 262);
                else
                    len = $urandom_range(1, 24);
                send_frame(len);
            end
        end
        gaps_on = 1'b0;
        drain();

        if (sb.errors == 0)
            $display("xor_checked_frame_builder_tb OK");
        else
            $display("xor_checked_frame_builder_tb NOT OK");
        $finish;
    end

endmodule

### filelist.f
rtl/xcfb_pkg.sv
rtl/xcfb_cfg.sv
rtl/xor_checked_frame_builder.sv
bench/xor_checked_frame_builder_tb.sv
